// ===== hdl/psa_pkg.sv =====
// shared types, codes and helpers for the purgeable segment allocator
`default_nettype none
package psa_pkg;

	// descriptor index, with one code kept for end of chain
	localparam int IDX_W = 6;
	typedef logic [IDX_W-1:0] idx_t;
	localparam idx_t NIL  = 6'd63;
	localparam idx_t HEAD = 6'd0;

	// one descriptor as held in the table memory
	typedef struct packed {
		logic [15:0] start;
		logic [15:0] length;
		logic        lock;
		logic [1:0]  purge;
		logic        own_v;
		logic [7:0]  own_h;
		idx_t        link;
	} desc_t;

	typedef enum logic [2:0] {
		OP_ALLOC, OP_FREE, OP_SET_PURGE, OP_SET_LOCK,
		OP_COMPACT, OP_QUERY_UNUSED, OP_QUERY_TOTAL, OP_REINIT
	} op_t;

	typedef enum logic [1:0] {KIND_DONE, KIND_CLEARED, KIND_MOVED} kind_t;

	typedef enum logic [1:0] {ST_OK, ST_NO_MEM, ST_NOT_FOUND, ST_NO_PURGE} st_t;

	// register indexes on the configuration port
	localparam logic REG_START = 1'b0;
	localparam logic REG_END   = 1'b1;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_DISP, S_FIN,
		S_FR_HD, S_FR_WALK, S_FR_ROV, S_FR_REL,
		S_CL_HD, S_CL_WALK,
		S_AL_SPR, S_PASS, S_AL_PREV, S_AL_SCAN, S_AL_FIT1, S_AL_FIT2, S_AL_REL,
		S_CP_BEGIN, S_CP_USE, S_CP_LINK, S_CP_DONE,
		S_SA, S_Q1, S_Q2
	} state_t;

	// first paragraph past a descriptor
	function automatic logic [16:0] end_of(desc_t d);
		return {1'b0, d.start} + {1'b0, d.length};
	endfunction

endpackage
`default_nettype wire

// ===== hdl/psa_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module psa_ram #(
	parameter int WIDTH = 50,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== hdl/purgeable_segment_allocator.sv =====
// Purgeable segment allocator: an address-ordered linked table of segment
// descriptors (16-byte paragraphs) kept in one synchronous RAM, walked by a
// sequencer one descriptor at a time. One request is taken at a time. The read
// of the next descriptor overlaps the use of the current one, so a walk
// visits about one descriptor per cycle while the result side does not stall.
// An oversized allocation is refused at dispatch, without a walk of the table.
// An allocation may first purge a block for a descriptor, then need all three
// passes and a compaction. A stall on the result side holds any pending beat.
// Notices (cleared handles, moves) come out as they are found, ahead of the
// final result. After reset the table is built by a pass that writes every
// descriptor before the first request is taken; reinit repeats that pass.
// Register writes take effect at the next reinit.
`default_nettype none
module purgeable_segment_allocator #(
	parameter int NUM_DESCRIPTORS = 32,
	parameter int NUM_HANDLES     = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [2:0]  opcode,
	input  wire logic [7:0]  handle,
	input  wire logic [19:0] size_bytes,
	input  wire logic [1:0]  purge_level,
	input  wire logic        lock_flag,
	// result channel
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [1:0]  kind,
	output      logic [1:0]  status,
	output      logic [7:0]  owner,
	output      logic [15:0] segment,
	output      logic [15:0] move_source,
	output      logic [15:0] move_length,
	output      logic [19:0] free_bytes,
	output      logic        last,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready
);
	import psa_pkg::*;

	localparam int AW = $clog2(NUM_DESCRIPTORS);
	localparam idx_t NDESC = IDX_W'(NUM_DESCRIPTORS);
	localparam idx_t LAST_IDX = IDX_W'(NUM_DESCRIPTORS - 1);

	function automatic logic ok_idx(idx_t i);
		return i < NDESC;
	endfunction

	// configuration registers
	logic [15:0] start_q, end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 16'd4096;
			end_q   <= 16'd40960;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_END) begin
				end_q <= pwdata[15:0];
			end else begin
				start_q <= pwdata[15:0];
			end
		end
	end

	assign pready = 1'b1;
	assign prdata = {16'd0, (paddr[2] == REG_END) ? end_q : start_q};

	// handle reduction table
	logic [7:0] hmod_tab [256];
	for (genvar g = 0; g < 256; g++) begin : g_hmod
		assign hmod_tab[g] = 8'(g % NUM_HANDLES);
	end

	// descriptor table
	logic    ram_we, ram_re;
	idx_t    ram_wi, ram_ri;
	desc_t   ram_wd, rd;
	logic [$bits(desc_t)-1:0] ram_rdata;

	psa_ram #(.WIDTH($bits(desc_t)), .DEPTH(NUM_DESCRIPTORS)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wi[AW-1:0]),
		.wdata (ram_wd),
		.re    (ram_re),
		.raddr (ram_ri[AW-1:0]),
		.rdata (ram_rdata)
	);
	assign rd = desc_t'(ram_rdata);

	// sequencer state
	state_t      state_q, state_n;
	op_t         op_q, op_n;
	logic [7:0]  h_q, h_n, key_q, key_n;
	logic [16:0] needed_q, needed_n;
	logic [1:0]  purge_q, purge_n, pass_q, pass_n;
	logic        lockf_q, lockf_n, clr_q, clr_n, init_fin_q, init_fin_n;
	idx_t        spare_q, spare_n, rover_q, rover_n, scan_q, scan_n, prev_q, prev_n;
	idx_t        nw_q, nw_n, pg_q, pg_n, nx_q, nx_n, endscan_q, endscan_n;
	idx_t        init_i_q, init_i_n;
	logic [16:0] startseg_q, startseg_n, pos_q, pos_n;
	logic [15:0] sum_q, sum_n;
	desc_t       cur_q, cur_n, prev_d_q, prev_d_n;
	st_t         fin_status_q, fin_status_n;
	logic [7:0]  fin_owner_q, fin_owner_n;
	logic [15:0] fin_seg_q, fin_seg_n;
	logic [19:0] fin_fb_q, fin_fb_n;

	// result register
	logic        ov_q, o_last_q;
	kind_t       o_kind_q;
	st_t         o_status_q;
	logic [7:0]  o_owner_q;
	logic [15:0] o_seg_q, o_src_q, o_len_q;
	logic [19:0] o_fb_q;

	logic        out_free;
	logic        em, em_last;
	kind_t       em_kind;
	st_t         em_status;
	logic [7:0]  em_owner;
	logic [15:0] em_seg, em_src, em_len;
	logic [19:0] em_fb;

	assign out_free = !ov_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	// next state, table accesses and beats
	always_comb begin
		desc_t       nd;
		desc_t       rel;
		logic [16:0] st17, gap, e17, g17;
		logic [17:0] acc;
		logic [15:0] add_len;
		logic [15:0] ls, le;
		idx_t        nlink;
		logic        mv;

		state_n = state_q; op_n = op_q; h_n = h_q; key_n = key_q;
		needed_n = needed_q; purge_n = purge_q; pass_n = pass_q;
		lockf_n = lockf_q; clr_n = clr_q; init_fin_n = init_fin_q;
		spare_n = spare_q; rover_n = rover_q; scan_n = scan_q; prev_n = prev_q;
		nw_n = nw_q; pg_n = pg_q; nx_n = nx_q; endscan_n = endscan_q;
		init_i_n = init_i_q; startseg_n = startseg_q; pos_n = pos_q;
		sum_n = sum_q; cur_n = cur_q; prev_d_n = prev_d_q;
		fin_status_n = fin_status_q; fin_owner_n = fin_owner_q;
		fin_seg_n = fin_seg_q; fin_fb_n = fin_fb_q;

		ram_we = 1'b0; ram_wi = HEAD; ram_wd = rd;
		ram_re = 1'b0; ram_ri = HEAD;

		em = 1'b0; em_last = 1'b0; em_kind = KIND_DONE; em_status = ST_OK;
		em_owner = 8'd0; em_seg = 16'd0; em_src = 16'd0; em_len = 16'd0;
		em_fb = 20'd0;

		rel = rd;
		rel.own_v = 1'b0;
		rel.own_h = 8'd0;
		rel.link = spare_q;
		nd = rd;
		st17 = {1'b0, rd.start};
		gap = (st17 >= startseg_q) ? st17 - startseg_q : 17'd0;
		e17 = end_of(cur_q);
		g17 = (st17 > e17) ? st17 - e17 : 17'd0;
		add_len = (op_q == OP_QUERY_TOTAL && cur_q.purge != 2'd0 && !cur_q.lock) ?
			cur_q.length : 16'd0;
		acc = {2'b0, sum_q} + {2'b0, add_len} + {1'b0, g17};
		ls = start_q;
		le = (end_q < start_q) ? start_q : end_q;
		nlink = rd.link;
		mv = 1'b0;

		unique case (state_q)
			// layout sweep
			S_INIT: begin
				ram_we = 1'b1;
				ram_wi = init_i_q;
				ram_wd = '0;
				if (init_i_q == HEAD) begin
					ram_wd.length = ls;
					ram_wd.lock = 1'b1;
					ram_wd.link = 6'd1;
				end else if (init_i_q == 6'd1) begin
					ram_wd.start = le;
					ram_wd.length = 16'hffff - le;
					ram_wd.lock = 1'b1;
					ram_wd.link = NIL;
				end else begin
					ram_wd.link = (init_i_q < LAST_IDX) ? init_i_q + 6'd1 : NIL;
				end
				init_i_n = init_i_q + 6'd1;
				if (init_i_q == LAST_IDX) begin
					spare_n = 6'd2;
					rover_n = HEAD;
					state_n = init_fin_q ? S_FIN : S_IDLE;
				end
			end

			S_IDLE: begin
				if (in_valid) begin
					op_n = op_t'(opcode);
					h_n = hmod_tab[handle];
					needed_n = 17'((21'(size_bytes) + 21'd15) >> 4);
					purge_n = purge_level;
					lockf_n = lock_flag;
					state_n = S_DISP;
				end
			end

			S_DISP: begin
				fin_status_n = ST_OK;
				fin_seg_n = 16'd0;
				fin_fb_n = 20'd0;
				fin_owner_n = (op_q == OP_ALLOC || op_q == OP_FREE ||
					op_q == OP_SET_PURGE || op_q == OP_SET_LOCK) ? h_q : 8'd0;
				clr_n = 1'b0;
				unique case (op_q) inside
					OP_ALLOC: begin
						if (needed_q[16]) begin
							fin_status_n = ST_NO_MEM;
							state_n = S_FIN;
						end else if (!ok_idx(spare_q)) begin
							clr_n = 1'b1;
							ram_re = 1'b1; ram_ri = HEAD;
							state_n = S_CL_HD;
						end else begin
							ram_re = 1'b1; ram_ri = spare_q;
							state_n = S_AL_SPR;
						end
					end
					OP_FREE: begin
						key_n = h_q;
						ram_re = 1'b1; ram_ri = HEAD;
						state_n = S_FR_HD;
					end
					OP_SET_PURGE, OP_SET_LOCK: begin
						scan_n = rover_q;
						ram_re = 1'b1; ram_ri = rover_q;
						state_n = S_SA;
					end
					OP_COMPACT: state_n = S_CP_BEGIN;
					OP_QUERY_UNUSED, OP_QUERY_TOTAL: begin
						sum_n = 16'd0;
						ram_re = 1'b1; ram_ri = HEAD;
						state_n = S_Q1;
					end
					default: begin
						init_i_n = HEAD;
						init_fin_n = 1'b1;
						state_n = S_INIT;
					end
				endcase
			end

			// final beat of a request
			S_FIN: begin
				if (out_free) begin
					em = 1'b1; em_last = 1'b1; em_status = fin_status_q;
					em_owner = fin_owner_q; em_seg = fin_seg_q; em_fb = fin_fb_q;
					state_n = S_IDLE;
				end
			end

			// free by handle: find, unlink, release
			S_FR_HD: begin
				prev_n = HEAD; prev_d_n = rd; scan_n = rd.link;
				if (!ok_idx(rd.link)) begin
					fin_status_n = clr_q ? ST_NO_PURGE : ST_NOT_FOUND;
					state_n = S_FIN;
				end else begin
					ram_re = 1'b1; ram_ri = rd.link;
					state_n = S_FR_WALK;
				end
			end
			S_FR_WALK: begin
				if (rd.own_v && rd.own_h == key_q) begin
					cur_n = rd;
					ram_re = 1'b1; ram_ri = rover_q;
					state_n = S_FR_ROV;
				end else begin
					prev_n = scan_q; prev_d_n = rd; scan_n = rd.link;
					if (!ok_idx(rd.link)) begin
						fin_status_n = clr_q ? ST_NO_PURGE : ST_NOT_FOUND;
						state_n = S_FIN;
					end else begin
						ram_re = 1'b1; ram_ri = rd.link;
					end
				end
			end
			S_FR_ROV: begin
				if (rd.own_v && rd.own_h == key_q) begin
					rover_n = HEAD;
				end
				ram_we = 1'b1; ram_wi = prev_q;
				ram_wd = prev_d_q; ram_wd.link = cur_q.link;
				state_n = S_FR_REL;
			end
			S_FR_REL: begin
				if (!cur_q.own_v || out_free) begin
					if (cur_q.own_v) begin
						em = 1'b1; em_kind = KIND_CLEARED; em_owner = cur_q.own_h;
					end
					ram_we = 1'b1; ram_wi = scan_q;
					ram_wd = cur_q; ram_wd.own_v = 1'b0; ram_wd.own_h = 8'd0;
					ram_wd.link = spare_q;
					if (clr_q) begin
						// the released entry is taken straight back for the new block
						nw_n = scan_q;
						clr_n = 1'b0;
						pass_n = 2'd0;
						state_n = S_PASS;
					end else begin
						spare_n = scan_q;
						state_n = S_FIN;
					end
				end
			end

			// descriptor shortage: first unlocked purgeable block
			S_CL_HD: begin
				scan_n = rd.link;
				if (!ok_idx(rd.link)) begin
					fin_status_n = ST_NO_PURGE;
					state_n = S_FIN;
				end else begin
					ram_re = 1'b1; ram_ri = rd.link;
					state_n = S_CL_WALK;
				end
			end
			S_CL_WALK: begin
				if (!rd.lock && rd.purge != 2'd0) begin
					key_n = rd.own_h;
					ram_re = 1'b1; ram_ri = HEAD;
					state_n = S_FR_HD;
				end else begin
					scan_n = rd.link;
					if (!ok_idx(rd.link)) begin
						fin_status_n = ST_NO_PURGE;
						state_n = S_FIN;
					end else begin
						ram_re = 1'b1; ram_ri = rd.link;
					end
				end
			end

			// allocation passes
			S_AL_SPR: begin
				nw_n = spare_q;
				spare_n = rd.link;
				pass_n = 2'd0;
				state_n = S_PASS;
			end
			S_PASS: begin
				case (pass_q)
					2'd0: begin
						prev_n = rover_q; endscan_n = NIL;
						ram_re = 1'b1; ram_ri = rover_q;
						state_n = S_AL_PREV;
					end
					2'd1: begin
						if (rover_q == HEAD) begin
							pass_n = 2'd2;
							state_n = S_CP_BEGIN;
						end else begin
							prev_n = HEAD; endscan_n = rover_q;
							ram_re = 1'b1; ram_ri = HEAD;
							state_n = S_AL_PREV;
						end
					end
					2'd2: state_n = S_CP_BEGIN;
					default: begin
						// no fit anywhere: give the descriptor back
						ram_we = 1'b1; ram_wi = nw_q; ram_wd = '0;
						ram_wd.length = needed_q[15:0];
						ram_wd.link = spare_q;
						spare_n = nw_q;
						fin_status_n = ST_NO_MEM;
						state_n = S_FIN;
					end
				endcase
			end
			S_AL_PREV: begin
				prev_d_n = rd; startseg_n = end_of(rd); scan_n = rd.link;
				if (rd.link == endscan_q || !ok_idx(rd.link)) begin
					pass_n = pass_q + 2'd1;
					state_n = S_PASS;
				end else begin
					ram_re = 1'b1; ram_ri = rd.link;
					state_n = S_AL_SCAN;
				end
			end
			S_AL_SCAN: begin
				if (gap >= needed_q) begin
					pg_n = prev_d_q.link;
					state_n = S_AL_FIT1;
				end else begin
					if (rd.lock || rd.purge == 2'd0) begin
						prev_n = scan_q; prev_d_n = rd; startseg_n = end_of(rd);
					end
					scan_n = rd.link;
					if (rd.link == endscan_q || !ok_idx(rd.link)) begin
						pass_n = pass_q + 2'd1;
						state_n = S_PASS;
					end else begin
						ram_re = 1'b1; ram_ri = rd.link;
					end
				end
			end
			S_AL_FIT1: begin
				ram_we = 1'b1; ram_wi = prev_q;
				ram_wd = prev_d_q; ram_wd.link = nw_q;
				state_n = S_AL_FIT2;
			end
			S_AL_FIT2: begin
				ram_we = 1'b1; ram_wi = nw_q; ram_wd = '0;
				ram_wd.start = startseg_q[15:0];
				ram_wd.length = needed_q[15:0];
				ram_wd.own_v = 1'b1; ram_wd.own_h = h_q;
				ram_wd.link = scan_q;
				if (pg_q != scan_q && ok_idx(pg_q)) begin
					ram_re = 1'b1; ram_ri = pg_q;
					state_n = S_AL_REL;
				end else begin
					rover_n = nw_q;
					fin_seg_n = startseg_q[15:0];
					state_n = S_FIN;
				end
			end
			// purgeable blocks covered by the new one
			S_AL_REL: begin
				if (!rd.own_v || out_free) begin
					if (rd.own_v) begin
						em = 1'b1; em_kind = KIND_CLEARED; em_owner = rd.own_h;
					end
					ram_we = 1'b1; ram_wi = pg_q; ram_wd = rel;
					spare_n = pg_q;
					pg_n = rd.link;
					if (rd.link != scan_q && ok_idx(rd.link)) begin
						ram_re = 1'b1; ram_ri = rd.link;
					end else begin
						rover_n = nw_q;
						fin_seg_n = startseg_q[15:0];
						state_n = S_FIN;
					end
				end
			end

			// compaction
			S_CP_BEGIN: begin
				scan_n = HEAD; prev_n = NIL; pos_n = 17'd0;
				ram_re = 1'b1; ram_ri = HEAD;
				state_n = S_CP_USE;
			end
			S_CP_USE: begin
				if (rd.lock) begin
					pos_n = end_of(rd); prev_n = scan_q; prev_d_n = rd;
					scan_n = nlink;
					if (ok_idx(nlink)) begin
						ram_re = 1'b1; ram_ri = nlink;
					end else begin
						state_n = S_CP_DONE;
					end
				end else if (rd.purge != 2'd0) begin
					if (!rd.own_v || out_free) begin
						if (rd.own_v) begin
							em = 1'b1; em_kind = KIND_CLEARED; em_owner = rd.own_h;
						end
						ram_we = 1'b1; ram_wi = scan_q; ram_wd = rel;
						spare_n = scan_q;
						nx_n = rd.link;
						state_n = S_CP_LINK;
					end
				end else begin
					mv = (st17 != pos_q);
					if (!mv || out_free) begin
						nd.start = pos_q[15:0];
						if (mv) begin
							em = 1'b1; em_kind = KIND_MOVED; em_owner = rd.own_h;
							em_seg = pos_q[15:0]; em_src = rd.start; em_len = rd.length;
							ram_we = 1'b1; ram_wi = scan_q; ram_wd = nd;
						end
						pos_n = end_of(nd); prev_n = scan_q; prev_d_n = nd;
						scan_n = nlink;
						if (ok_idx(nlink)) begin
							ram_re = 1'b1; ram_ri = nlink;
						end else begin
							state_n = S_CP_DONE;
						end
					end
				end
			end
			S_CP_LINK: begin
				if (ok_idx(prev_q)) begin
					ram_we = 1'b1; ram_wi = prev_q;
					ram_wd = prev_d_q; ram_wd.link = nx_q;
				end
				prev_d_n.link = nx_q;
				scan_n = nx_q;
				if (ok_idx(nx_q)) begin
					ram_re = 1'b1; ram_ri = nx_q;
					state_n = S_CP_USE;
				end else begin
					state_n = S_CP_DONE;
				end
			end
			S_CP_DONE: begin
				rover_n = HEAD;
				if (op_q == OP_ALLOC) begin
					prev_n = HEAD; endscan_n = NIL;
					ram_re = 1'b1; ram_ri = HEAD;
					state_n = S_AL_PREV;
				end else begin
					state_n = S_FIN;
				end
			end

			// set purge level or lock, circular search from the rover
			S_SA: begin
				if (rd.own_v && rd.own_h == h_q) begin
					rover_n = scan_q;
					if (op_q == OP_SET_LOCK) begin
						nd.lock = lockf_q;
					end else begin
						nd.purge = purge_q;
					end
					ram_we = 1'b1; ram_wi = scan_q; ram_wd = nd;
					state_n = S_FIN;
				end else begin
					if (!ok_idx(rd.link)) begin
						nlink = HEAD;
					end
					if (nlink == rover_q) begin
						fin_status_n = ST_NOT_FOUND;
						state_n = S_FIN;
					end else begin
						scan_n = nlink;
						ram_re = 1'b1; ram_ri = nlink;
					end
				end
			end

			// free space queries
			S_Q1: begin
				cur_n = rd;
				if (!ok_idx(rd.link)) begin
					state_n = S_FIN;
				end else begin
					ram_re = 1'b1; ram_ri = rd.link;
					state_n = S_Q2;
				end
			end
			S_Q2: begin
				sum_n = (acc > 18'h0ffff) ? 16'hffff : acc[15:0];
				cur_n = rd;
				if (!ok_idx(rd.link)) begin
					fin_fb_n = {sum_n, 4'd0};
					state_n = S_FIN;
				end else begin
					ram_re = 1'b1; ram_ri = rd.link;
				end
			end

			default: state_n = S_IDLE;
		endcase
	end

	// sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			init_i_q   <= HEAD;
			init_fin_q <= 1'b0;
			spare_q    <= 6'd2;
			rover_q    <= HEAD;
			clr_q      <= 1'b0;
			pass_q     <= 2'd0;
		end else begin
			state_q    <= state_n;
			init_i_q   <= init_i_n;
			init_fin_q <= init_fin_n;
			spare_q    <= spare_n;
			rover_q    <= rover_n;
			clr_q      <= clr_n;
			pass_q     <= pass_n;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		op_q <= op_n; h_q <= h_n; key_q <= key_n; needed_q <= needed_n;
		purge_q <= purge_n; lockf_q <= lockf_n;
		scan_q <= scan_n; prev_q <= prev_n; nw_q <= nw_n; pg_q <= pg_n;
		nx_q <= nx_n; endscan_q <= endscan_n;
		startseg_q <= startseg_n; pos_q <= pos_n; sum_q <= sum_n;
		cur_q <= cur_n; prev_d_q <= prev_d_n;
		fin_status_q <= fin_status_n; fin_owner_q <= fin_owner_n;
		fin_seg_q <= fin_seg_n; fin_fb_q <= fin_fb_n;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (em) begin
			ov_q <= 1'b1;
		end else if (!out_stall) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (em) begin
			o_kind_q <= em_kind; o_status_q <= em_status; o_owner_q <= em_owner;
			o_seg_q <= em_seg; o_src_q <= em_src; o_len_q <= em_len;
			o_fb_q <= em_fb; o_last_q <= em_last;
		end
	end

	assign out_valid   = ov_q;
	assign kind        = o_kind_q;
	assign status      = o_status_q;
	assign owner       = o_owner_q;
	assign segment     = o_seg_q;
	assign move_source = o_src_q;
	assign move_length = o_len_q;
	assign free_bytes  = o_fb_q;
	assign last        = o_last_q;
endmodule
`default_nettype wire
